/* hdl/sisc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sisc_pkg
// Shared widths, register map and constants of the sigma-clip mean block.
// ----------------------------------------------------------------------------
package sisc_pkg;

	localparam int SAMPLE_W  = 24;      // conversion word
	localparam int CNT_W     = 7;       // sample_count register
	localparam int DEV_W     = 24;      // acceptable_deviation register
	localparam int MEAN_W    = 32;      // mean, 8 fraction bits
	localparam int FRAC_W    = 8;
	localparam int PCT_W     = 7;
	localparam int PCT_SCALE = 100;

	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	localparam logic [CNT_W-1:0] CNT_RESET = 7'd16;
	localparam logic [DEV_W-1:0] DEV_RESET = 24'd524288;   // 1 pF in counts

	// register index (paddr / 4)
	localparam logic REG_SAMPLE_COUNT = 1'b0;
	localparam logic REG_ACC_DEV      = 1'b1;

endpackage

/* hdl/sisc_in_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sisc_in_if
// Sample channel: valid/ready handshake with one conversion word.
// ----------------------------------------------------------------------------
interface sisc_in_if import sisc_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] sample;

	modport source (output valid, sample, input ready);
	modport sink   (input valid, sample, output ready);
endinterface

/* hdl/sisc_out_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sisc_out_if
// Result channel: valid/ready handshake with mean, reliability and status.
// ----------------------------------------------------------------------------
interface sisc_out_if import sisc_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [MEAN_W-1:0] mean_value;
	logic [PCT_W-1:0]         reliability_percent;
	logic                     status;

	modport source (output valid, mean_value, reliability_percent, status, input ready);
	modport sink   (input valid, mean_value, reliability_percent, status, output ready);
endinterface

/* hdl/sisc_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sisc_front
// Takes samples, writes them to the store and posts a batch job when full.
// ----------------------------------------------------------------------------
module sisc_front import sisc_pkg::*; #(
	parameter int MAX_SAMPLES = 64
) (
	input  logic                               clk,
	input  logic                               arst_n,
	sisc_in_if.sink                            smp,
	input  logic [CNT_W-1:0]                   sample_count,
	input  logic                               batch_done,
	output logic                               wr_en,
	output logic [$clog2(MAX_SAMPLES)-1:0]     wr_addr,
	output logic [SAMPLE_W-1:0]                wr_data,
	output logic                               job_valid,
	output logic [$clog2(MAX_SAMPLES+1)-1:0]   job_total,
	input  logic                               job_ready
);
	localparam int NW = $clog2(MAX_SAMPLES + 1);
	localparam int AW = $clog2(MAX_SAMPLES);

	logic [NW-1:0] loaded_q;
	logic          hold_q;      // batch handed off, store owned by back end
	logic [NW-1:0] target;
	logic [NW-1:0] next_cnt;
	logic          acc;
	logic          close;

	always_comb begin
		if (sample_count == '0) begin
			target = NW'(1);
		end else if (int'(sample_count) > MAX_SAMPLES) begin
			target = NW'(MAX_SAMPLES);
		end else begin
			target = NW'(sample_count);
		end
	end

	assign smp.ready = !hold_q && job_ready;
	assign acc       = smp.valid && smp.ready;
	assign next_cnt  = loaded_q + NW'(1);
	assign close     = acc && (next_cnt >= target);

	assign wr_en     = acc;
	assign wr_addr   = loaded_q[AW-1:0];
	assign wr_data   = smp.sample;
	assign job_valid = close;
	assign job_total = next_cnt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loaded_q <= '0;
			hold_q   <= 1'b0;
		end else begin
			if (acc) begin
				loaded_q <= close ? '0 : next_cnt;
			end
			if (close) begin
				hold_q <= 1'b1;
			end else if (batch_done) begin
				hold_q <= 1'b0;
			end
		end
	end
endmodule

/* hdl/sisc_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sisc_queue
// Two-entry job queue between front and back end.
// ----------------------------------------------------------------------------
module sisc_queue #(
	parameter int DW = 7
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic [DW-1:0] in_data,
	output logic          in_ready,
	output logic          out_valid,
	output logic [DW-1:0] out_data,
	input  logic          out_ready
);
	logic [DW-1:0] ent_q [2];
	logic          wp_q;
	logic          rp_q;
	logic [1:0]    cnt_q;
	logic          push;
	logic          pop;

	assign in_ready  = (cnt_q != 2'd2);
	assign out_valid = (cnt_q != 2'd0);
	assign out_data  = ent_q[rp_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wp_q] <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= !wp_q;
			end
			if (pop) begin
				rp_q <= !rp_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end
endmodule

/* hdl/sisc_mul.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sisc_mul
// Digit-serial multiplier: wide A times B, one 8-bit digit of B per cycle.
// ----------------------------------------------------------------------------
module sisc_mul #(
	parameter int A_W = 69,
	parameter int B_W = 31
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           go,
	input  logic [A_W-1:0] a,
	input  logic [B_W-1:0] b,
	output logic           done,
	output logic [A_W-1:0] p
);
	localparam int ND = (B_W + 7) / 8;
	localparam int BP = ND * 8;
	localparam int CW = $clog2(ND + 1);

	logic [A_W-1:0] a_q;
	logic [BP-1:0]  b_q;
	logic [A_W-1:0] p_q;
	logic [CW-1:0]  cnt_q;
	logic           busy_q;
	logic           done_q;

	assign done = done_q;
	assign p    = p_q;

	always_ff @(posedge clk) begin
		if (go) begin
			a_q <= a;
			b_q <= BP'(b);
			p_q <= '0;
		end else if (busy_q) begin
			p_q <= p_q + a_q * b_q[7:0];
			a_q <= a_q << 8;
			b_q <= b_q >> 8;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				cnt_q  <= CW'(ND);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end
endmodule

/* hdl/sisc_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sisc_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sisc_div #(
	parameter int DV_W = 39,
	parameter int DS_W = 7
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            go,
	input  logic [DV_W-1:0] dividend,
	input  logic [DS_W-1:0] divisor,
	output logic            done,
	output logic [DV_W-1:0] quot
);
	localparam int CW = $clog2(DV_W + 1);

	logic [DV_W-1:0] quot_q;
	logic [DS_W-1:0] rem_q;
	logic [DS_W-1:0] dsr_q;
	logic [CW-1:0]   cnt_q;
	logic            busy_q;
	logic            done_q;
	logic [DS_W:0]   trial;
	logic [DS_W:0]   diff;
	logic            fits;

	assign trial = {rem_q, quot_q[DV_W-1]};
	assign diff  = trial - {1'b0, dsr_q};
	assign fits  = (trial >= {1'b0, dsr_q});
	assign done  = done_q;
	assign quot  = quot_q;

	always_ff @(posedge clk) begin
		if (go) begin
			quot_q <= dividend;
			rem_q  <= '0;
			dsr_q  <= divisor;
		end else if (busy_q) begin
			rem_q  <= fits ? diff[DS_W-1:0] : trial[DS_W-1:0];
			quot_q <= {quot_q[DV_W-2:0], fits};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				cnt_q  <= CW'(DV_W);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end
endmodule

/* hdl/sisc_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sisc_back
// Sample store and clipping sequencer: sum pass, exact variance test,
// clip pass, final divisions and the result register.
// ----------------------------------------------------------------------------
module sisc_back import sisc_pkg::*; #(
	parameter int MAX_SAMPLES = 64
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               wr_en,
	input  logic [$clog2(MAX_SAMPLES)-1:0]     wr_addr,
	input  logic [SAMPLE_W-1:0]                wr_data,
	input  logic                               job_valid,
	input  logic [$clog2(MAX_SAMPLES+1)-1:0]   job_total,
	output logic                               job_ready,
	input  logic [DEV_W-1:0]                   acc_dev,
	sisc_out_if.source                         res,
	output logic                               batch_done
);
	localparam int NW  = $clog2(MAX_SAMPLES + 1);
	localparam int AW  = $clog2(MAX_SAMPLES);
	localparam int SW  = NW + SAMPLE_W + 1;            // signed sum, n*x
	localparam int QW  = NW + 2 * SAMPLE_W - 1;        // sum of squares
	localparam int BB  = NW + SAMPLE_W;                // narrow multiplier operand
	localparam int W   = 3 * NW + 2 * SAMPLE_W;        // exact compare width
	localparam int DVW = BB + FRAC_W;                  // dividend width
	localparam int PW  = NW + PCT_W;

	localparam logic [4:0] ST_IDLE  = 5'd0;
	localparam logic [4:0] ST_PASS  = 5'd1;
	localparam logic [4:0] ST_S_RD  = 5'd2;
	localparam logic [4:0] ST_S_SQ  = 5'd3;
	localparam logic [4:0] ST_S_ACC = 5'd4;
	localparam logic [4:0] ST_CHK   = 5'd5;
	localparam logic [4:0] ST_W_QN  = 5'd6;
	localparam logic [4:0] ST_W_SS  = 5'd7;
	localparam logic [4:0] ST_W_TT  = 5'd8;
	localparam logic [4:0] ST_W_TN  = 5'd9;
	localparam logic [4:0] ST_W_TL  = 5'd10;
	localparam logic [4:0] ST_W_DN  = 5'd11;
	localparam logic [4:0] ST_C_RD  = 5'd12;
	localparam logic [4:0] ST_C_MX  = 5'd13;
	localparam logic [4:0] ST_C_DF  = 5'd14;
	localparam logic [4:0] ST_W_D2  = 5'd15;
	localparam logic [4:0] ST_W_D3  = 5'd16;
	localparam logic [4:0] ST_C_NXT = 5'd17;
	localparam logic [4:0] ST_C_END = 5'd18;
	localparam logic [4:0] ST_FIN   = 5'd19;
	localparam logic [4:0] ST_W_DV1 = 5'd20;
	localparam logic [4:0] ST_W_DV2 = 5'd21;
	localparam logic [4:0] ST_OUT   = 5'd22;

	logic [SAMPLE_W-1:0]        store [MAX_SAMPLES];
	logic [SAMPLE_W-1:0]        rd_q;

	logic [4:0]                 state_q;
	logic [NW-1:0]              total_q;
	logic [NW-1:0]              idx_q;
	logic [NW-1:0]              n_q;
	logic [NW-1:0]              newn_q;
	logic [MAX_SAMPLES-1:0]     keep_q;
	logic                       err_q;
	logic signed [SW-1:0]       s_q;
	logic [QW-1:0]              qs_q;
	logic signed [SAMPLE_W-1:0] x_q;
	logic [QW-1:0]              sq_q;
	logic [W-1:0]               pa_q;
	logic [W-1:0]               d_q;
	logic [W-1:0]               rhs_q;
	logic signed [SW-1:0]       nx_q;

	logic                       mul_go_q;
	logic [W-1:0]               mul_a_q;
	logic [BB-1:0]              mul_b_q;
	logic                       mul_done;
	logic [W-1:0]               mul_p;
	logic                       dv_go_q;
	logic [DVW-1:0]             dv_a_q;
	logic [NW-1:0]              dv_b_q;
	logic                       dv_done;
	logic [DVW-1:0]             dv_q;

	logic                       out_v_q;
	logic [MEAN_W-1:0]          mv_q;
	logic [PCT_W-1:0]           pct_q;
	logic [MEAN_W-1:0]          mean_q;
	logic [PCT_W-1:0]           out_pct_q;
	logic                       out_err_q;

	logic [AW-1:0]              ia;
	logic                       last;
	logic signed [2*SAMPLE_W-1:0] sq_full;
	logic signed [SW-1:0]       nx_full;
	logic [SW-1:0]              s_abs;
	logic [BB-1:0]              s_mag;
	logic signed [SW-1:0]       diff;
	logic [SW-1:0]              diff_abs;
	logic [BB-1:0]              d_mag;
	logic [PW-1:0]              n100;
	logic                       take;

	assign ia       = idx_q[AW-1:0];
	assign last     = ((idx_q + NW'(1)) == total_q);
	assign sq_full  = $signed(rd_q) * $signed(rd_q);
	assign nx_full  = $signed({1'b0, n_q}) * $signed(rd_q);
	assign s_abs    = s_q[SW-1] ? -s_q : s_q;
	assign s_mag    = s_abs[BB-1:0];
	assign diff     = nx_q - s_q;
	assign diff_abs = diff[SW-1] ? -diff : diff;
	assign d_mag    = diff_abs[BB-1:0];
	assign n100     = PW'(n_q) * PW'(PCT_SCALE);
	assign take     = (state_q == ST_OUT) && (!out_v_q || res.ready);

	assign job_ready  = (state_q == ST_IDLE);
	assign batch_done = take;

	assign res.valid               = out_v_q;
	assign res.mean_value          = mean_q;
	assign res.reliability_percent = out_pct_q;
	assign res.status              = out_err_q;

	// store: one write port (front), one registered read port at idx
	always_ff @(posedge clk) begin
		if (wr_en) begin
			store[wr_addr] <= wr_data;
		end
		rd_q <= store[ia];
	end

	sisc_mul #(.A_W(W), .B_W(BB)) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (mul_go_q),
		.a      (mul_a_q),
		.b      (mul_b_q),
		.done   (mul_done),
		.p      (mul_p)
	);

	sisc_div #(.DV_W(DVW), .DS_W(NW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (dv_go_q),
		.dividend (dv_a_q),
		.divisor  (dv_b_q),
		.done     (dv_done),
		.quot     (dv_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			keep_q   <= '1;
			err_q    <= 1'b0;
			mul_go_q <= 1'b0;
			dv_go_q  <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			mul_go_q <= 1'b0;
			dv_go_q  <= 1'b0;
			if (res.ready) begin
				out_v_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (job_valid) begin
						total_q <= job_total;
						keep_q  <= '1;
						err_q   <= 1'b0;
						state_q <= ST_PASS;
					end
				end
				ST_PASS: begin
					idx_q   <= '0;
					s_q     <= '0;
					qs_q    <= '0;
					n_q     <= '0;
					state_q <= ST_S_RD;
				end
				ST_S_RD: begin
					state_q <= ST_S_SQ;
				end
				ST_S_SQ: begin
					x_q     <= $signed(rd_q);
					sq_q    <= QW'(sq_full[2*SAMPLE_W-2:0]);
					state_q <= ST_S_ACC;
				end
				ST_S_ACC: begin
					if (keep_q[ia]) begin
						s_q  <= s_q + SW'(x_q);
						qs_q <= qs_q + sq_q;
						n_q  <= n_q + NW'(1);
					end
					idx_q   <= idx_q + NW'(1);
					state_q <= last ? ST_CHK : ST_S_RD;
				end
				ST_CHK: begin
					if (n_q < NW'(2)) begin
						err_q   <= 1'b1;
						state_q <= ST_FIN;
					end else begin
						// d = q*n - s^2
						mul_a_q  <= W'(qs_q);
						mul_b_q  <= BB'(n_q);
						mul_go_q <= 1'b1;
						state_q  <= ST_W_QN;
					end
				end
				ST_W_QN: begin
					if (mul_done) begin
						pa_q     <= mul_p;
						mul_a_q  <= W'(s_mag);
						mul_b_q  <= s_mag;
						mul_go_q <= 1'b1;
						state_q  <= ST_W_SS;
					end
				end
				ST_W_SS: begin
					if (mul_done) begin
						d_q      <= pa_q - mul_p;
						mul_a_q  <= W'(acc_dev);
						mul_b_q  <= BB'(acc_dev);
						mul_go_q <= 1'b1;
						state_q  <= ST_W_TT;
					end
				end
				ST_W_TT: begin
					if (mul_done) begin
						mul_a_q  <= mul_p;
						mul_b_q  <= BB'(n_q);
						mul_go_q <= 1'b1;
						state_q  <= ST_W_TN;
					end
				end
				ST_W_TN: begin
					if (mul_done) begin
						mul_a_q  <= mul_p;
						mul_b_q  <= BB'(n_q - NW'(1));
						mul_go_q <= 1'b1;
						state_q  <= ST_W_TL;
					end
				end
				ST_W_TL: begin
					// stop when d < T^2 n (n-1), i.e. deviation under threshold, or when n <= 2
					if (mul_done) begin
						if (d_q < mul_p || n_q <= NW'(2)) begin
							state_q <= ST_FIN;
						end else begin
							mul_a_q  <= d_q;
							mul_b_q  <= BB'(n_q);
							mul_go_q <= 1'b1;
							state_q  <= ST_W_DN;
						end
					end
				end
				ST_W_DN: begin
					if (mul_done) begin
						rhs_q   <= mul_p;
						idx_q   <= '0;
						newn_q  <= '0;
						state_q <= ST_C_RD;
					end
				end
				ST_C_RD: begin
					state_q <= ST_C_MX;
				end
				ST_C_MX: begin
					if (keep_q[ia]) begin
						nx_q    <= nx_full;
						state_q <= ST_C_DF;
					end else begin
						state_q <= ST_C_NXT;
					end
				end
				ST_C_DF: begin
					mul_a_q  <= W'(d_mag);
					mul_b_q  <= d_mag;
					mul_go_q <= 1'b1;
					state_q  <= ST_W_D2;
				end
				ST_W_D2: begin
					if (mul_done) begin
						mul_a_q  <= mul_p;
						mul_b_q  <= BB'(n_q - NW'(1));
						mul_go_q <= 1'b1;
						state_q  <= ST_W_D3;
					end
				end
				ST_W_D3: begin
					// keep only when (n x - s)^2 (n-1) < d n
					if (mul_done) begin
						if (mul_p < rhs_q) begin
							newn_q <= newn_q + NW'(1);
						end else begin
							keep_q[ia] <= 1'b0;
						end
						state_q <= ST_C_NXT;
					end
				end
				ST_C_NXT: begin
					idx_q   <= idx_q + NW'(1);
					state_q <= last ? ST_C_END : ST_C_RD;
				end
				ST_C_END: begin
					state_q <= (newn_q == n_q) ? ST_FIN : ST_PASS;
				end
				ST_FIN: begin
					dv_go_q <= 1'b1;
					if (n_q == '0) begin
						mv_q    <= '0;
						dv_a_q  <= DVW'(n100);
						dv_b_q  <= total_q;
						state_q <= ST_W_DV2;
					end else begin
						dv_a_q  <= {s_mag, FRAC_W'(0)};
						dv_b_q  <= n_q;
						state_q <= ST_W_DV1;
					end
				end
				ST_W_DV1: begin
					if (dv_done) begin
						mv_q    <= s_q[SW-1] ? -dv_q[MEAN_W-1:0] : dv_q[MEAN_W-1:0];
						dv_a_q  <= DVW'(n100);
						dv_b_q  <= total_q;
						dv_go_q <= 1'b1;
						state_q <= ST_W_DV2;
					end
				end
				ST_W_DV2: begin
					if (dv_done) begin
						pct_q   <= dv_q[PCT_W-1:0];
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (take) begin
						mean_q    <= mv_q;
						out_pct_q <= pct_q;
						out_err_q <= err_q;
						out_v_q   <= 1'b1;
						state_q   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end
endmodule

/* hdl/iterative_sigma_clip_mean.sv */
`timescale 1ns / 1ps
// Flow: a word is taken every cycle while a batch loads; after the last word each
//   pass runs a sum walk over the store and the exact variance test (the multiplier
//   works in 8-bit digits, 4 at 64); a failing test adds a clipping walk over every
//   word, kept or dropped; then the back end divides for the mean and the percent.
// Throughput: one batch at a time; input stalls from batch close to result latch.
// Reset: arst_n async low; registers return to 16 and 524288, counters clear.
// ----------------------------------------------------------------------------
// iterative_sigma_clip_mean
// Sigma-clipped mean of a batch of signed 24-bit samples, APB-configured.
// ----------------------------------------------------------------------------
//
// Structure
//   front : takes sample words, writes the store, closes the batch when
//           sample_count words are in (0 acts as 1, clamped to MAX_SAMPLES).
//   queue : two-entry job queue carrying the batch size to the back end.
//   back  : owns the store; walks it to get sum and sum of squares, tests
//           q*n - s^2 against T^2*n*(n-1) exactly (no root), clips words with
//           (n*x - s)^2*(n-1) >= (q*n - s^2)*n, repeats until stable, then
//           divides for the mean (8 fraction bits, toward zero) and percent.
//   The front holds off new samples while the back end owns the store; the
//   result sits in an output register so the next batch can load meanwhile.
//
// Register map (32-bit data, byte address = 4 * index)
//   0x0 sample_count          7 bits
//   0x4 acceptable_deviation  24 bits
module iterative_sigma_clip_mean import sisc_pkg::*; #(
	parameter int MAX_SAMPLES = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	sisc_in_if.sink            smp,
	sisc_out_if.source         res
);
	localparam int NW = $clog2(MAX_SAMPLES + 1);
	localparam int AW = $clog2(MAX_SAMPLES);

	logic [CNT_W-1:0]    sample_count_q;
	logic [DEV_W-1:0]    acc_dev_q;
	logic                reg_idx;
	logic                cfg_wr;

	logic                wr_en;
	logic [AW-1:0]       wr_addr;
	logic [SAMPLE_W-1:0] wr_data;
	logic                fj_valid;
	logic [NW-1:0]       fj_total;
	logic                fj_ready;
	logic                bj_valid;
	logic [NW-1:0]       bj_total;
	logic                bj_ready;
	logic                batch_done;

	// ---- configuration port: write on the access phase, zero wait states
	assign pready  = 1'b1;
	assign reg_idx = paddr[2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_comb begin
		unique case (reg_idx)
			REG_SAMPLE_COUNT: prdata = PDATA_W'(sample_count_q);
			REG_ACC_DEV:      prdata = PDATA_W'(acc_dev_q);
			default:          prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_count_q <= CNT_RESET;
			acc_dev_q      <= DEV_RESET;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_SAMPLE_COUNT: sample_count_q <= pwdata[CNT_W-1:0];
				REG_ACC_DEV:      acc_dev_q      <= pwdata[DEV_W-1:0];
				default:          ;
			endcase
		end
	end

	// ---- front end: load words into the store, close batches
	sisc_front #(.MAX_SAMPLES(MAX_SAMPLES)) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.smp          (smp),
		.sample_count (sample_count_q),
		.batch_done   (batch_done),
		.wr_en        (wr_en),
		.wr_addr      (wr_addr),
		.wr_data      (wr_data),
		.job_valid    (fj_valid),
		.job_total    (fj_total),
		.job_ready    (fj_ready)
	);

	// ---- job queue
	sisc_queue #(.DW(NW)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fj_valid),
		.in_data   (fj_total),
		.in_ready  (fj_ready),
		.out_valid (bj_valid),
		.out_data  (bj_total),
		.out_ready (bj_ready)
	);

	// ---- back end: clipping passes, divides, result register
	sisc_back #(.MAX_SAMPLES(MAX_SAMPLES)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr_en      (wr_en),
		.wr_addr    (wr_addr),
		.wr_data    (wr_data),
		.job_valid  (bj_valid),
		.job_total  (bj_total),
		.job_ready  (bj_ready),
		.acc_dev    (acc_dev_q),
		.res        (res),
		.batch_done (batch_done)
	);
endmodule
